/* rtl/psg_tone_noise_envelope_unit_macros.svh */
// ----------------------------------------------------------------------------
// PSG assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PSG_TONE_NOISE_ENVELOPE_UNIT_MACROS_SVH
`define PSG_TONE_NOISE_ENVELOPE_UNIT_MACROS_SVH

// same-cycle implication
`define PSG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psg check failed (same cycle)");

// next-cycle implication
`define PSG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psg check failed (next cycle)");

`endif

/* rtl/psg_tne_pkg.sv */
// ----------------------------------------------------------------------------
// PSG tone/noise/envelope package
// Commands, register map, level table and stream packing constants.
// ----------------------------------------------------------------------------
package psg_tne_pkg;

  typedef enum logic [1:0] {
    CMD_SELECT = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_TICK   = 2'd3
  } psg_cmd_e;

  localparam int unsigned NUM_REGS = 16;
  localparam int unsigned NUM_CH   = 3;

  localparam logic [3:0] REG_TONE_A_HI = 4'd1;
  localparam logic [3:0] REG_TONE_B_HI = 4'd3;
  localparam logic [3:0] REG_TONE_C_HI = 4'd5;
  localparam logic [3:0] REG_NOISE     = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_AMP_A     = 4'd8;
  localparam logic [3:0] REG_AMP_B     = 4'd9;
  localparam logic [3:0] REG_AMP_C     = 4'd10;
  localparam logic [3:0] REG_ENV_LO    = 4'd11;
  localparam logic [3:0] REG_ENV_HI    = 4'd12;
  localparam logic [3:0] REG_SHAPE     = 4'd13;

  localparam logic [7:0] MIXER_RESET = 8'h3F;
  localparam logic [7:0] MASK_NIBBLE = 8'h0F;
  localparam logic [7:0] MASK_FIVE   = 8'h1F;

  // floor(x / 3) = (x * DIV3_RECIP) >> DIV3_SHIFT for x < 2**17
  localparam int unsigned SUM_W      = 17;
  localparam logic [15:0] DIV3_RECIP = 16'd43691;
  localparam int unsigned DIV3_SHIFT = 17;

  // output tdata layout, lowest bit first
  localparam int unsigned RD_LSB     = 0;
  localparam int unsigned LVL_A_LSB  = 8;
  localparam int unsigned LVL_B_LSB  = 12;
  localparam int unsigned LVL_C_LSB  = 16;
  localparam int unsigned MIX_LSB    = 20;
  localparam int unsigned ENV_LSB    = 35;
  localparam int unsigned OUT_TDATA_W = 40;

  function automatic logic [14:0] level_q15(input logic [3:0] idx);
    logic [14:0] v;
    unique case (idx)
      4'd0:  v = 15'd0;
      4'd1:  v = 15'd449;
      4'd2:  v = 15'd672;
      4'd3:  v = 15'd954;
      4'd4:  v = 15'd1386;
      4'd5:  v = 15'd2025;
      4'd6:  v = 15'd2775;
      4'd7:  v = 15'd4486;
      4'd8:  v = 15'd5541;
      4'd9:  v = 15'd8674;
      4'd10: v = 15'd11557;
      4'd11: v = 15'd14742;
      4'd12: v = 15'd18691;
      4'd13: v = 15'd22521;
      4'd14: v = 15'd27794;
      default: v = 15'd32767;
    endcase
    return v;
  endfunction

endpackage

/* rtl/psg_tone_noise_envelope_unit.sv */
// ----------------------------------------------------------------------------
// PSG tone/noise/envelope unit
// Pipeline: input reg, state/level stage, mix-sum stage, divide-by-3
//   multiply into the output register. Throughput: one beat per cycle
//   unless the output stalls; stages advance independently under stall.
// Reset: async active low; registers 0..15 cleared (mixer to 0x3F), noise
//   LFSR to 1, envelope and counters cleared, pipeline emptied.
// ----------------------------------------------------------------------------
module psg_tone_noise_envelope_unit
  import psg_tne_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_wdata_i,     // channel_mute
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,    // [7:0] data
  input  logic [1:0]             s_axis_tuser,    // [1:0] cmd
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] read_data, [11:8] level_a, [15:12] level_b, [19:16] level_c,
  // [34:20] mix_level, [38:35] env_level, [39] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // stage valids and advance
  logic v0_q, v1_q, v2_q, v3_q;
  logic adv0, adv1, adv2, adv3;

  assign adv3 = ~v3_q | m_axis_tready;
  assign adv2 = ~v2_q | adv3;
  assign adv1 = ~v1_q | adv2;
  assign adv0 = ~v0_q | adv1;
  assign s_axis_tready = adv0;

  logic [2:0] mute_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mute_q <= '0;
    end else if (cfg_we_i) begin
      mute_q <= cfg_wdata_i;
    end
  end

  // input register
  psg_cmd_e   cmd_q;
  logic [7:0] data_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv0) begin
      v0_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv0 && s_axis_tvalid) begin
      cmd_q  <= psg_cmd_e'(s_axis_tuser);
      data_q <= s_axis_tdata;
    end
  end

  // generator state
  logic [7:0]  regs_q [NUM_REGS];
  logic [7:0]  regs_d [NUM_REGS];
  logic [3:0]  sel_q, sel_d;
  logic [11:0] tone_cnt_q [NUM_CH];
  logic [11:0] tone_cnt_d [NUM_CH];
  logic [2:0]  phase_q, phase_d;
  logic [5:0]  noise_cnt_q, noise_cnt_d;
  logic [16:0] noise_q, noise_d;
  logic [15:0] env_cnt_q, env_cnt_d;
  logic [3:0]  env_vol_q, env_vol_d;
  logic        holding_q, holding_d;
  logic        cont_q, cont_d;
  logic        attack_q, attack_d;
  logic        alt_q, alt_d;
  logic        hold_q, hold_d;

  logic        upd;
  assign upd = v0_q & adv1;

  logic [11:0] tone_p;
  logic [11:0] tone_inc;
  logic [5:0]  noise_lim;
  logic [5:0]  noise_inc;
  logic [15:0] env_p;
  logic [15:0] env_inc;
  logic [7:0]  wval;
  logic        ramp_end;

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      regs_d[i] = regs_q[i];
    end
    sel_d       = sel_q;
    tone_cnt_d  = tone_cnt_q;
    phase_d     = phase_q;
    noise_cnt_d = noise_cnt_q;
    noise_d     = noise_q;
    env_cnt_d   = env_cnt_q;
    env_vol_d   = env_vol_q;
    holding_d   = holding_q;
    cont_d      = cont_q;
    attack_d    = attack_q;
    alt_d       = alt_q;
    hold_d      = hold_q;
    tone_p      = '0;
    tone_inc    = '0;
    noise_lim   = '0;
    noise_inc   = '0;
    env_p       = '0;
    env_inc     = '0;
    wval        = data_q;
    ramp_end    = 1'b0;

    unique case (cmd_q)
      CMD_SELECT: begin
        sel_d = data_q[3:0];
      end
      CMD_WRITE: begin
        if (sel_q == REG_TONE_A_HI || sel_q == REG_TONE_B_HI ||
            sel_q == REG_TONE_C_HI || sel_q == REG_SHAPE) begin
          wval = data_q & MASK_NIBBLE;
        end else if (sel_q == REG_NOISE || sel_q == REG_AMP_A ||
                     sel_q == REG_AMP_B || sel_q == REG_AMP_C) begin
          wval = data_q & MASK_FIVE;
        end
        regs_d[sel_q] = wval;
        if (sel_q == REG_SHAPE) begin
          env_cnt_d = '0;
          holding_d = 1'b0;
          cont_d    = wval[3];
          attack_d  = wval[2];
          alt_d     = wval[1];
          hold_d    = wval[0];
          env_vol_d = wval[2] ? 4'd0 : 4'd15;
        end
      end
      CMD_READ: begin
      end
      CMD_TICK: begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          tone_p   = {regs_q[2*ch+1][3:0], regs_q[2*ch]};
          tone_p   = (tone_p == '0) ? 12'd1 : tone_p;
          tone_inc = tone_cnt_q[ch] + 12'd1;
          if (tone_inc >= tone_p) begin
            tone_cnt_d[ch] = '0;
            phase_d[ch]    = ~phase_q[ch];
          end else begin
            tone_cnt_d[ch] = tone_inc;
          end
        end

        noise_lim = (regs_q[REG_NOISE][4:0] == '0) ? 6'd2 : {regs_q[REG_NOISE][4:0], 1'b0};
        noise_inc = noise_cnt_q + 6'd1;
        if (noise_inc >= noise_lim) begin
          noise_cnt_d = '0;
          noise_d     = {noise_q[0] ^ noise_q[3], noise_q[16:1]};
        end else begin
          noise_cnt_d = noise_inc;
        end

        if (!holding_q) begin
          env_p   = {regs_q[REG_ENV_HI], regs_q[REG_ENV_LO]};
          env_p   = (env_p == '0) ? 16'd1 : env_p;
          env_inc = env_cnt_q + 16'd1;
          if (env_inc >= env_p) begin
            env_cnt_d = '0;
            if (attack_q) begin
              if (env_vol_q != 4'd15) env_vol_d = env_vol_q + 4'd1;
              else                    ramp_end  = 1'b1;
            end else begin
              if (env_vol_q != 4'd0)  env_vol_d = env_vol_q - 4'd1;
              else                    ramp_end  = 1'b1;
            end
          end else begin
            env_cnt_d = env_inc;
          end
          if (ramp_end) begin
            priority if (!cont_q) begin
              env_vol_d = 4'd0;
              holding_d = 1'b1;
            end else if (hold_q) begin
              if (alt_q) env_vol_d = attack_q ? 4'd0 : 4'd15;
              holding_d = 1'b1;
            end else if (alt_q) begin
              attack_d = ~attack_q;
            end else begin
              env_vol_d = attack_q ? 4'd0 : 4'd15;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= (i == int'(REG_MIXER)) ? MIXER_RESET : 8'h00;
      end
      sel_q       <= '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        tone_cnt_q[ch] <= '0;
      end
      phase_q     <= '0;
      noise_cnt_q <= '0;
      noise_q     <= 17'd1;
      env_cnt_q   <= '0;
      env_vol_q   <= '0;
      holding_q   <= 1'b0;
      cont_q      <= 1'b0;
      attack_q    <= 1'b0;
      alt_q       <= 1'b0;
      hold_q      <= 1'b0;
    end else if (upd) begin
      regs_q      <= regs_d;
      sel_q       <= sel_d;
      tone_cnt_q  <= tone_cnt_d;
      phase_q     <= phase_d;
      noise_cnt_q <= noise_cnt_d;
      noise_q     <= noise_d;
      env_cnt_q   <= env_cnt_d;
      env_vol_q   <= env_vol_d;
      holding_q   <= holding_d;
      cont_q      <= cont_d;
      attack_q    <= attack_d;
      alt_q       <= alt_d;
      hold_q      <= hold_d;
    end
  end

  // gated levels from the post-update state
  logic [3:0] lvl_d [NUM_CH];
  logic [7:0] mixer_d;
  logic [7:0] amp_d;
  logic [3:0] vol_d;

  always_comb begin
    mixer_d = regs_d[REG_MIXER];
    amp_d   = '0;
    vol_d   = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      amp_d     = regs_d[int'(REG_AMP_A) + ch];
      vol_d     = amp_d[4] ? env_vol_d : amp_d[3:0];
      lvl_d[ch] = ((phase_d[ch] | mixer_d[ch]) & (noise_d[0] | mixer_d[ch+3])) ? vol_d : 4'd0;
    end
  end

  // stage 1: levels, read data, envelope
  logic [3:0] lvl1_q [NUM_CH];
  logic [7:0] rd1_q;
  logic [3:0] env1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= v0_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (upd) begin
      lvl1_q <= lvl_d;
      rd1_q  <= regs_d[sel_d];
      env1_q <= env_vol_d;
    end
  end

  // stage 2: table lookup and sum
  logic [SUM_W-1:0] sum_d, sum2_q;
  logic [3:0]       lvl2_q [NUM_CH];
  logic [7:0]       rd2_q;
  logic [3:0]       env2_q;

  always_comb begin
    sum_d = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (!mute_q[ch]) sum_d = sum_d + SUM_W'(level_q15(lvl1_q[ch]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      sum2_q <= sum_d;
      lvl2_q <= lvl1_q;
      rd2_q  <= rd1_q;
      env2_q <= env1_q;
    end
  end

  // stage 3: divide by 3 via reciprocal multiply
  logic [SUM_W+15:0] prod;
  logic [14:0]       mix_d;
  assign prod  = sum2_q * DIV3_RECIP;
  assign mix_d = prod[DIV3_SHIFT +: 15];

  logic [OUT_TDATA_W-1:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv3) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      out_q <= {1'b0, env2_q, mix_d, lvl2_q[2], lvl2_q[1], lvl2_q[0], rd2_q};
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = out_q;

endmodule

/* rtl/psg_tne_checker.sv */
// ----------------------------------------------------------------------------
// PSG port checker
// Port-level checks on stream behavior, bound to the top level.
// ----------------------------------------------------------------------------
`include "psg_tone_noise_envelope_unit_macros.svh"

module psg_tne_checker
  import psg_tne_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic all_gated_off;
  assign all_gated_off = (m_axis_tdata[LVL_A_LSB +: 4] == 4'd0) &&
                         (m_axis_tdata[LVL_B_LSB +: 4] == 4'd0) &&
                         (m_axis_tdata[LVL_C_LSB +: 4] == 4'd0);

  // a stalled result beat holds its payload
  `PSG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // input side only backs up under an output stall
  `PSG_ASSERT_NOW(a_in_backpressure, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // silent channels mix to silence
  `PSG_ASSERT_NOW(a_mix_silent, m_axis_tvalid && all_gated_off, m_axis_tdata[MIX_LSB +: 15] == 15'd0)

  // pad bit stays clear
  `PSG_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1] == 1'b0)

endmodule

bind psg_tone_noise_envelope_unit psg_tne_checker u_psg_tne_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
